### sv/flight_state_supervisor_macros.svh
// assertion macros for the supervisor rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef FLIGHT_STATE_SUPERVISOR_MACROS_SVH
`define FLIGHT_STATE_SUPERVISOR_MACROS_SVH

// same-cycle implication under reset
`define FSS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("supervisor check failed");

// next-cycle implication under reset
`define FSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("supervisor check failed");

`endif

### sv/fss_pkg.sv
// flight state supervisor package: codes, item and result types, helpers
// no dependencies
package fss_pkg;

    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned PAIR_W  = 2;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [VOLT_W-1:0] ARM_BLOCK_RST  = 16'd3300;
    localparam logic [VOLT_W-1:0] VALID_MIN_RST  = 16'd100;
    localparam logic [TIME_W-1:0] GRACE_RST      = 32'd3000000;

    typedef enum logic [1:0] {
        REG_ARM_BLOCK = 2'd0,
        REG_VALID_MIN = 2'd1,
        REG_GRACE     = 2'd2,
        REG_NONE      = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        OP_INIT_DONE     = 4'd0,
        OP_ARM           = 4'd1,
        OP_DISARM        = 4'd2,
        OP_ESTOP         = 4'd3,
        OP_TAKEOFF       = 4'd4,
        OP_TAKEOFF_DONE  = 4'd5,
        OP_LAND_REQ      = 4'd6,
        OP_LAND_DONE     = 4'd7,
        OP_SOFT_LAND     = 4'd8,
        OP_HELD          = 4'd9,
        OP_MODE          = 4'd10,
        OP_ALERT         = 4'd11,
        OP_PAIR_REQ      = 4'd12,
        OP_PAIR_DONE     = 4'd13,
        OP_TICK          = 4'd14,
        OP_FORCE_IDLE    = 4'd15
    } t_op;

    localparam logic [KIND_W-1:0] ALERT_IMPACT    = 3'd0;
    localparam logic [KIND_W-1:0] ALERT_GYRO      = 3'd1;
    localparam logic [KIND_W-1:0] ALERT_COMM_LOST = 3'd2;
    localparam logic [KIND_W-1:0] ALERT_LOW_BATT  = 3'd3;
    localparam logic [KIND_W-1:0] ALERT_EST_DIV   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_STABILIZE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALT_HOLD  = 2'd2;

    localparam logic [PAIR_W-1:0] PAIR_NONE   = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_SEARCH = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_DONE   = 2'd2;

    typedef enum logic [6:0] {
        ST_INIT         = 7'b0000001,
        ST_IDLE_GROUND  = 7'b0000010,
        ST_IDLE_HELD    = 7'b0000100,
        ST_ARMED_GROUND = 7'b0001000,
        ST_TAKEOFF      = 7'b0010000,
        ST_FLYING       = 7'b0100000,
        ST_LANDING      = 7'b1000000
    } t_fstate;

    localparam logic [CODE_W-1:0] CODE_INIT         = 3'd0;
    localparam logic [CODE_W-1:0] CODE_IDLE_GROUND  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_IDLE_HELD    = 3'd2;
    localparam logic [CODE_W-1:0] CODE_ARMED_GROUND = 3'd3;
    localparam logic [CODE_W-1:0] CODE_TAKEOFF      = 3'd4;
    localparam logic [CODE_W-1:0] CODE_FLYING       = 3'd5;
    localparam logic [CODE_W-1:0] CODE_LANDING      = 3'd6;

    typedef struct packed {
        logic [VOLT_W-1:0] arm_block_voltage_mv;
        logic [VOLT_W-1:0] voltage_valid_min_mv;
        logic [TIME_W-1:0] hover_grace_us;
    } t_cfg;

    typedef struct packed {
        t_op               operation;
        logic              is_held;
        logic [MODE_W-1:0] requested_mode;
        logic [KIND_W-1:0] alert_kind;
        logic              alert_emergency;
        logic [VOLT_W-1:0] voltage_mv;
        logic              calibrated;
        logic [TIME_W-1:0] time_us;
    } t_item;

    typedef struct packed {
        logic              comm_loss_pending;
        logic              pairing_tone;
        logic              estimator_reset;
        logic              mode_changed;
        logic              state_changed;
        logic              accepted;
        logic [PAIR_W-1:0] pairing_status;
        logic              armed;
        logic [MODE_W-1:0] flight_mode;
        logic [CODE_W-1:0] flight_state;
    } t_result;

    function automatic logic [CODE_W-1:0] state_code(input t_fstate s);
        logic [CODE_W-1:0] c;
        case (s)
            ST_INIT:         c = CODE_INIT;
            ST_IDLE_GROUND:  c = CODE_IDLE_GROUND;
            ST_IDLE_HELD:    c = CODE_IDLE_HELD;
            ST_ARMED_GROUND: c = CODE_ARMED_GROUND;
            ST_TAKEOFF:      c = CODE_TAKEOFF;
            ST_FLYING:       c = CODE_FLYING;
            ST_LANDING:      c = CODE_LANDING;
            default:         c = CODE_INIT;
        endcase
        return c;
    endfunction

    function automatic logic is_armed(input t_fstate s);
        return (s == ST_ARMED_GROUND) || (s == ST_TAKEOFF) ||
               (s == ST_FLYING) || (s == ST_LANDING);
    endfunction

    function automatic logic is_airborne(input t_fstate s);
        return (s == ST_TAKEOFF) || (s == ST_FLYING) || (s == ST_LANDING);
    endfunction

endpackage

### sv/fss_cfg.sv
// apb configuration registers of the supervisor
// depends on fss_pkg
module fss_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fss_pkg::ADDR_W-1:0] paddr,
    input  logic [fss_pkg::DATA_W-1:0] pwdata,
    output logic [fss_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output fss_pkg::t_cfg              o_cfg
);
    import fss_pkg::*;

    t_cfg r_cfg;
    t_reg w_idx;
    logic w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arm_block_voltage_mv <= ARM_BLOCK_RST;
            r_cfg.voltage_valid_min_mv <= VALID_MIN_RST;
            r_cfg.hover_grace_us       <= GRACE_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_ARM_BLOCK: r_cfg.arm_block_voltage_mv <= pwdata[VOLT_W-1:0];
                REG_VALID_MIN: r_cfg.voltage_valid_min_mv <= pwdata[VOLT_W-1:0];
                REG_GRACE:     r_cfg.hover_grace_us       <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ARM_BLOCK: prdata = {{(DATA_W-VOLT_W){1'b0}}, r_cfg.arm_block_voltage_mv};
            REG_VALID_MIN: prdata = {{(DATA_W-VOLT_W){1'b0}}, r_cfg.voltage_valid_min_mv};
            REG_GRACE:     prdata = r_cfg.hover_grace_us;
            default:       prdata = '0;
        endcase
    end

endmodule

### sv/fss_core.sv
// supervisor state registers and the per-event next-state logic
// depends on fss_pkg
module fss_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  fss_pkg::t_item   i_item,
    input  fss_pkg::t_cfg    i_cfg,
    output fss_pkg::t_result o_result
);
    import fss_pkg::*;

    t_fstate           r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic [PAIR_W-1:0] r_pair, n_pair;
    logic              r_pend, n_pend;
    logic [TIME_W-1:0] r_start, n_start;

    t_fstate           tgt;
    logic              go, st_chg, md_chg, acc, est, tone;
    logic              volt_block;
    logic [TIME_W-1:0] elapsed;

    assign volt_block = (i_item.voltage_mv > i_cfg.voltage_valid_min_mv) &&
                        (i_item.voltage_mv <= i_cfg.arm_block_voltage_mv);
    assign elapsed    = i_item.time_us - r_start;

    always_comb begin
        n_mode  = r_mode;
        n_pair  = r_pair;
        n_pend  = r_pend;
        n_start = r_start;
        go      = 1'b0;
        tgt     = r_state;
        acc     = 1'b0;
        est     = 1'b0;
        tone    = 1'b0;
        md_chg  = 1'b0;
        case (i_item.operation)
            OP_INIT_DONE: begin
                if (r_state == ST_INIT) begin
                    go  = 1'b1;
                    tgt = ST_IDLE_GROUND;
                end
            end
            OP_ARM: begin
                if (r_state == ST_IDLE_GROUND && r_pair != PAIR_SEARCH &&
                    !volt_block && i_item.calibrated) begin
                    go  = 1'b1;
                    tgt = ST_ARMED_GROUND;
                    acc = 1'b1;
                end
            end
            OP_DISARM: begin
                if (is_armed(r_state)) begin
                    acc = 1'b1;
                    go  = 1'b1;
                    if (r_state == ST_FLYING && r_mode >= MODE_ALT_HOLD) begin
                        tgt = ST_LANDING;
                    end else begin
                        tgt = ST_IDLE_GROUND;
                    end
                end
            end
            OP_ESTOP: begin
                if (is_armed(r_state)) begin
                    acc = 1'b1;
                    go  = 1'b1;
                    tgt = ST_IDLE_GROUND;
                end
            end
            OP_TAKEOFF: begin
                if (r_state == ST_ARMED_GROUND) begin
                    go  = 1'b1;
                    tgt = ST_TAKEOFF;
                end
            end
            OP_TAKEOFF_DONE: begin
                if (r_state == ST_TAKEOFF) begin
                    go  = 1'b1;
                    tgt = ST_FLYING;
                end
            end
            OP_LAND_REQ: begin
                if (r_state == ST_FLYING) begin
                    go  = 1'b1;
                    tgt = ST_LANDING;
                end
            end
            OP_LAND_DONE: begin
                if (r_state == ST_LANDING) begin
                    go  = 1'b1;
                    tgt = ST_IDLE_GROUND;
                end
            end
            OP_SOFT_LAND: begin
                if (r_state == ST_FLYING) begin
                    go  = 1'b1;
                    tgt = ST_ARMED_GROUND;
                end
            end
            OP_HELD: begin
                if (i_item.is_held && r_state == ST_IDLE_GROUND) begin
                    go  = 1'b1;
                    tgt = ST_IDLE_HELD;
                end else if (!i_item.is_held && r_state == ST_IDLE_HELD) begin
                    go  = 1'b1;
                    tgt = ST_IDLE_GROUND;
                end
            end
            OP_MODE: begin
                if (r_state == ST_IDLE_GROUND || r_state == ST_ARMED_GROUND ||
                    r_state == ST_FLYING) begin
                    acc = 1'b1;
                    if (i_item.requested_mode != r_mode) begin
                        n_mode = i_item.requested_mode;
                        md_chg = 1'b1;
                    end
                end
            end
            OP_ALERT: begin
                if (i_item.alert_kind == ALERT_IMPACT || i_item.alert_kind == ALERT_GYRO) begin
                    if (is_armed(r_state)) begin
                        go  = 1'b1;
                        tgt = ST_IDLE_GROUND;
                    end
                end else if (i_item.alert_kind == ALERT_COMM_LOST) begin
                    if (is_airborne(r_state) && !r_pend) begin
                        n_pend  = 1'b1;
                        n_start = i_item.time_us;
                    end
                end else if (i_item.alert_kind == ALERT_LOW_BATT) begin
                    if (i_item.alert_emergency && is_airborne(r_state) &&
                        r_state != ST_LANDING) begin
                        go  = 1'b1;
                        tgt = ST_LANDING;
                    end
                end else if (i_item.alert_kind == ALERT_EST_DIV) begin
                    est = 1'b1;
                end
            end
            OP_PAIR_REQ: begin
                if ((r_state == ST_IDLE_GROUND || r_state == ST_IDLE_HELD) &&
                    r_pair != PAIR_SEARCH) begin
                    n_pair = PAIR_SEARCH;
                    tone   = 1'b1;
                end
            end
            OP_PAIR_DONE: begin
                n_pair = PAIR_DONE;
            end
            OP_TICK: begin
                if (r_pend) begin
                    if (!is_airborne(r_state)) begin
                        n_pend = 1'b0;
                    end else if (r_state == ST_FLYING && elapsed >= i_cfg.hover_grace_us) begin
                        n_pend = 1'b0;
                        go     = 1'b1;
                        tgt    = ST_LANDING;
                    end
                end
            end
            OP_FORCE_IDLE: begin
                go  = 1'b1;
                tgt = ST_IDLE_GROUND;
            end
            default: begin
                go  = 1'b1;
                tgt = ST_IDLE_GROUND;
            end
        endcase

        // entering idle ground forces stabilize
        st_chg  = go && (tgt != r_state);
        n_state = st_chg ? tgt : r_state;
        if (st_chg && tgt == ST_IDLE_GROUND && r_mode != MODE_STABILIZE) begin
            n_mode = MODE_STABILIZE;
            md_chg = 1'b1;
        end
    end

    always_comb begin
        o_result.flight_state      = state_code(n_state);
        o_result.flight_mode       = n_mode;
        o_result.armed             = is_armed(n_state);
        o_result.pairing_status    = n_pair;
        o_result.accepted          = acc;
        o_result.state_changed     = st_chg;
        o_result.mode_changed      = md_chg;
        o_result.estimator_reset   = est;
        o_result.pairing_tone      = tone;
        o_result.comm_loss_pending = n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_mode  <= MODE_STABILIZE;
            r_pair  <= PAIR_NONE;
            r_pend  <= 1'b0;
            r_start <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_pair  <= n_pair;
            r_pend  <= n_pend;
            r_start <= n_start;
        end
    end

endmodule

### sv/flight_state_supervisor.sv
// flight state supervisor top level: input register, core, result register
// depends on fss_pkg, fss_cfg, fss_core and flight_state_supervisor_macros.svh
//
// usage
// - events enter on the s_axis channel, one word per event; the event kind
//   rides in s_axis_tuser, its arguments in s_axis_tdata
// - each event gives exactly one result word on the m_axis channel carrying
//   the flight state, mode, pairing status and per-event flags
// - an accepted word shows its result on m_axis after two register stages:
//   input then result
// - throughput: one event per cycle without back-pressure; the input register
//   hands it to the single-pass state update once the result register is free
// - when m_axis_tready is low the result is held and one more event waits in
//   the input register, then s_axis_tready drops
// - reset (i_rst_n low, synchronous) empties both registers and sets state
//   init, mode stabilize, not paired, no comm-loss timer; registers return
//   to 3300 mv, 100 mv and 3000000 us
// - the apb port writes thresholds at 0x0, 0x4, 0x8; write it only while
//   the block holds no event
`include "flight_state_supervisor_macros.svh"

module flight_state_supervisor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // is_held, requested_mode, alert_kind, alert_emergency, voltage_mv,
    // calibrated, time_us (lowest bit up)
    input  logic [55:0] s_axis_tdata,
    // operation
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // flight_state, flight_mode, armed, pairing_status, accepted,
    // state_changed, mode_changed, estimator_reset, pairing_tone,
    // comm_loss_pending, two zero bits (lowest bit up)
    output logic [15:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fss_pkg::*;

    t_item   w_item;
    t_item   r_item;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    t_cfg    w_cfg;
    logic    w_in_fire;
    logic    w_adv;
    logic    w_idle_entry;
    logic    w_armed_code;

    assign w_item.operation       = t_op'(s_axis_tuser);
    assign w_item.is_held         = s_axis_tdata[0];
    assign w_item.requested_mode  = s_axis_tdata[2:1];
    assign w_item.alert_kind      = s_axis_tdata[5:3];
    assign w_item.alert_emergency = s_axis_tdata[6];
    assign w_item.voltage_mv      = s_axis_tdata[22:7];
    assign w_item.calibrated      = s_axis_tdata[23];
    assign w_item.time_us         = s_axis_tdata[55:24];

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    fss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fss_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_item <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    assign w_idle_entry = r_out_valid && r_out.state_changed &&
                          (r_out.flight_state == CODE_IDLE_GROUND);
    assign w_armed_code = (r_out.flight_state >= CODE_ARMED_GROUND) &&
                          (r_out.flight_state <= CODE_LANDING);

    // a waiting word is never dropped while the core is blocked
    `FSS_ASSERT_NEXT(a_in_hold, r_in_valid && !w_adv, r_in_valid)
    // entering idle ground always sets stabilize mode
    `FSS_ASSERT_IMPL(a_idle_mode, w_idle_entry, r_out.flight_mode == MODE_STABILIZE)
    // a pairing tone only comes with an active search
    `FSS_ASSERT_IMPL(a_tone_search, r_out_valid && r_out.pairing_tone, r_out.pairing_status == PAIR_SEARCH)
    // the armed flag follows the reported state
    `FSS_ASSERT_IMPL(a_armed_code, r_out_valid && r_out.armed, w_armed_code)

endmodule
